/* src/sfms_pkg.sv */
// ----------------------------------------------------------------------------
// sfms_pkg
// Shared opcodes and inter-cell types for the first-match sequence search.
// ----------------------------------------------------------------------------
package sfms_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;  // append one pattern word
  localparam logic [1:0] OP_TEXT   = 2'd1;  // stream one text word
  localparam logic [1:0] OP_FINISH = 2'd2;  // report and clear

  // Broadcast controls from the top level to every cell
  typedef struct packed {
    logic load;   // pattern word offered to the first empty cell
    logic step;   // text word to compare this cycle
    logic clear;  // finish: drop pattern and match state
  } cell_ctrl_t;

  // What a cell hands to its right-hand neighbour
  typedef struct packed {
    logic loaded;  // this cell holds a pattern word
    logic match;   // pattern prefix up to this cell matched so far
  } cell_link_t;

endpackage

/* src/sfms_cell.sv */
// ----------------------------------------------------------------------------
// sfms_cell
// One pattern position: stored word, fill flag and shift-and match bit.
// ----------------------------------------------------------------------------
module sfms_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfms_pkg::cell_ctrl_t  ctrl,
  input  logic [WORD_BITS-1:0]  word,
  input  sfms_pkg::cell_link_t  prev,
  input  logic                  next_loaded,
  output sfms_pkg::cell_link_t  link,
  output logic                  tail_hit
);

  logic [WORD_BITS-1:0] word_r;
  logic                 loaded_r, loaded_nxt;
  logic                 match_r, match_nxt;
  logic                 take_word;
  logic                 cmp;

  // first empty cell takes the appended word
  assign take_word = ctrl.load && !loaded_r && prev.loaded;
  assign cmp       = prev.match && (word_r == word);

  always_comb begin
    loaded_nxt = loaded_r;
    match_nxt  = match_r;
    if (ctrl.clear) begin
      loaded_nxt = 1'b0;
      match_nxt  = 1'b0;
    end else begin
      if (take_word) begin
        loaded_nxt = 1'b1;
      end
      if (ctrl.step && loaded_r) begin
        match_nxt = cmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
      match_r  <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_word) begin
      word_r <= word;
    end
  end

  assign link.loaded = loaded_r;
  assign link.match  = match_r;
  // last filled cell matching means the whole pattern just matched
  assign tail_hit    = ctrl.step && loaded_r && !next_loaded && cmp;

endmodule

/* src/subsequence_first_match_search_top.sv */
// ----------------------------------------------------------------------------
// subsequence_first_match_search_top
// Streaming first-occurrence search of a word pattern in a word text.
// ----------------------------------------------------------------------------
// One transaction of any opcode is taken every clock cycle unless the input
// is held off, as set out below. The pattern sits in a row
// of MAX_PATTERN cells; each text word is compared against every stored word
// at once and each cell passes its match bit to its neighbour (shift-and), so
// the cycle is set by one word compare plus an OR across the cells' tail
// hits. A finish loads the result into the output register at the edge that
// accepts it, so the result is offered from the next cycle, and clears the
// search. While a result waits and the receiver is not taking it, the input
// is held off for every opcode; there is no other stall.
// Appends after the first text word are ignored, a full pattern store or a
// saturated text counter raises the overflow flag, and an empty pattern
// reports found at index 0.
// ----------------------------------------------------------------------------
module subsequence_first_match_search_top #(
  parameter int MAX_PATTERN = 16,
  parameter int WORD_BITS   = 32,
  parameter int INDEX_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  input  logic [WORD_BITS-1:0] in_element_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [15:0]          out_match_index,
  output logic                 out_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SUB_W = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
  localparam int OUT_W = (INDEX_BITS > 16) ? INDEX_BITS : 16;

  // ---- search state ----
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [INDEX_BITS-1:0] text_cnt_r, text_cnt_nxt;
  logic                  hit_seen_r, hit_seen_nxt;
  logic [INDEX_BITS-1:0] hit_pos_r, hit_pos_nxt;
  logic                  ovf_r, ovf_nxt;

  // ---- output register ----
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [15:0]           out_index_r;
  logic                  out_ovf_r;

  logic                  in_fire;
  logic                  is_append, is_text, is_finish;
  logic                  pattern_full, text_sat, text_idle;
  logic                  any_hit;
  logic [INDEX_BITS-1:0] text_inc;
  logic [SUB_W-1:0]      hit_calc;
  logic [OUT_W-1:0]      index_wide;

  sfms_pkg::cell_ctrl_t  ctrl;
  sfms_pkg::cell_link_t  chain [MAX_PATTERN+1];
  logic [MAX_PATTERN:0]  loaded_vec;
  logic [MAX_PATTERN-1:0] tail_hit_vec;

  // Input taken whenever no held result would be lost
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign is_append = in_fire && (in_opcode == sfms_pkg::OP_APPEND);
  assign is_text   = in_fire && (in_opcode == sfms_pkg::OP_TEXT);
  assign is_finish = in_fire && (in_opcode == sfms_pkg::OP_FINISH);

  assign pattern_full = loaded_vec[MAX_PATTERN-1];
  assign text_sat     = (text_cnt_r == {INDEX_BITS{1'b1}});
  assign text_idle    = (text_cnt_r == '0);   // pattern still open for appends
  assign text_inc     = text_cnt_r + INDEX_BITS'(1);

  assign ctrl.load  = is_append && text_idle && !pattern_full;
  assign ctrl.step  = is_text && !text_sat && !hit_seen_r;
  assign ctrl.clear = is_finish;

  // ---- cell row ----
  // Cell 0 sees a virtual left neighbour that is always full and matching.
  assign chain[0].loaded = 1'b1;
  assign chain[0].match  = 1'b1;
  assign loaded_vec[MAX_PATTERN] = 1'b0;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    sfms_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .word        (in_element_value),
      .prev        (chain[k]),
      .next_loaded (loaded_vec[k+1]),
      .link        (chain[k+1]),
      .tail_hit    (tail_hit_vec[k])
    );
    assign loaded_vec[k] = chain[k+1].loaded;
  end

  assign any_hit  = |tail_hit_vec;
  // start index = words seen including this one, less the pattern length
  assign hit_calc = SUB_W'(text_inc) - SUB_W'(len_r);

  // ---- state update ----
  always_comb begin
    len_nxt      = len_r;
    text_cnt_nxt = text_cnt_r;
    hit_seen_nxt = hit_seen_r;
    hit_pos_nxt  = hit_pos_r;
    ovf_nxt      = ovf_r;
    if (is_finish) begin
      len_nxt      = '0;
      text_cnt_nxt = '0;
      hit_seen_nxt = 1'b0;
      hit_pos_nxt  = '0;
      ovf_nxt      = 1'b0;
    end else if (is_append) begin
      if (ctrl.load) begin
        len_nxt = len_r + LEN_W'(1);
      end else if (text_idle) begin
        ovf_nxt = 1'b1;               // store full, word dropped
      end
    end else if (is_text) begin
      if (text_sat) begin
        ovf_nxt = 1'b1;               // counter saturated, word dropped
      end else begin
        text_cnt_nxt = text_inc;
        if (any_hit) begin
          hit_seen_nxt = 1'b1;
          hit_pos_nxt  = hit_calc[INDEX_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      text_cnt_r <= '0;
      hit_seen_r <= 1'b0;
      hit_pos_r  <= '0;
      ovf_r      <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      text_cnt_r <= text_cnt_nxt;
      hit_seen_r <= hit_seen_nxt;
      hit_pos_r  <= hit_pos_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // ---- result register ----
  assign index_wide = hit_seen_r ? OUT_W'(hit_pos_r) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (is_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_finish) begin
      out_found_r <= hit_seen_r || (len_r == '0);
      out_index_r <= index_wide[15:0];
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;
  assign out_overflow    = out_ovf_r;

  // ---- assertions ----
  a_fill_thermo : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(loaded_vec[MAX_PATTERN-1:0]) == int'(len_r))
    else $error("cell fill flags disagree with pattern length");

  a_one_tail : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tail_hit_vec))
    else $error("more than one cell reports a full match");

  a_hit_needs_pattern : assert property (@(posedge clk) disable iff (!rst_n)
    hit_seen_r |-> (len_r != '0))
    else $error("match recorded with an empty pattern");

  a_finish_clears : assert property (@(posedge clk) disable iff (!rst_n)
    is_finish |=> (len_r == '0) && (text_cnt_r == '0) && !hit_seen_r && !ovf_r)
    else $error("search state not cleared after finish");

  a_not_found_index : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_index_r == '0))
    else $error("non-zero index reported without a match");

endmodule
